// File: design/bwrm_pkg.sv
// bwrm_pkg: shared types and constants for the buffer watermark refill monitor
// no dependencies; used by every module of the block

package bwrm_pkg;

    // fixed field widths
    localparam int FILL_W  = 24;
    localparam int PCT_W   = 7;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // serial divider: quotient bits resolved one per cycle
    localparam int DIV_STEPS = 7;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // percent constants and register reset values
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] MEAN_RESET  = 7'd80;
    localparam logic [PCT_W-1:0] LOW_RESET   = 7'd50;
    localparam logic [PCT_W-1:0] HIGH_RESET  = 7'd90;
    localparam logic [PCT_W-1:0] TGT_RESET   = 7'd75;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LOW_MARK  = 2'd0;
    localparam logic [1:0] REG_HIGH_MARK = 2'd1;
    localparam logic [1:0] REG_TARGET    = 2'd2;

    typedef struct packed {
        logic              playing;
        logic [FILL_W-1:0] fill_bytes;
        logic [FILL_W-1:0] capacity_bytes;
        logic [CNT_W-1:0]  played_before;
        logic [CNT_W-1:0]  played_after;
        logic [SUM_W-1:0]  read_ticks;
    } item_t;

    typedef struct packed {
        logic             sampled;
        logic [PCT_W-1:0] current_pct;
        logic [PCT_W-1:0] min_pct;
        logic [PCT_W-1:0] max_pct;
        logic [PCT_W-1:0] avg_pct;
        logic             refilling;
        logic             update_request;
        logic [CNT_W-1:0] chunks_total;
        logic [SUM_W-1:0] bytes_total;
        logic [SUM_W-1:0] ticks_total;
    } result_t;

    typedef struct packed {
        logic [PCT_W-1:0] low_mark_pct;
        logic [PCT_W-1:0] high_mark_pct;
        logic [PCT_W-1:0] target_pct;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic check;
        logic div_start;
        logic div_sel_mean;
        logic apply_pct;
        logic apply_mean;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sampleable;
        logic div_done;
    } dp_status_t;

endpackage

// File: design/bwrm_div.sv
// bwrm_div: serial restoring divider giving a 7-bit quotient, forced to 100 when it would reach 128 or more
// depends on bwrm_pkg

module bwrm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bwrm_pkg::SUM_W-1:0]    dividend,
    input  logic [bwrm_pkg::SUM_W-1:0]    divisor,
    output logic                          done,
    output logic [bwrm_pkg::PCT_W-1:0]    quotient
);
    import bwrm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     dsr_reg;
    logic [PCT_W-1:0]     low_reg;
    logic [PCT_W-1:0]     q_reg;

    logic                 ovf;
    logic [SUM_W+1:0]     trial;
    logic                 ge;
    logic [SUM_W-1:0]     rem_next;

    // quotient of 128 or more saturates straight away
    assign ovf = {{PCT_W{1'b0}}, dividend[SUM_W-1:PCT_W]} >= divisor;

    // one trial subtraction per cycle
    assign trial    = {1'b0, rem_reg, low_reg[PCT_W-1]} - {2'b00, dsr_reg};
    assign ge       = ~trial[SUM_W+1];
    assign rem_next = ge ? trial[SUM_W-1:0] : {rem_reg[SUM_W-2:0], low_reg[PCT_W-1]};

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (ovf)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(DIV_STEPS - 1);
                end
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{PCT_W{1'b0}}, dividend[SUM_W-1:PCT_W]};
            low_reg <= dividend[PCT_W-1:0];
            dsr_reg <= divisor;
            q_reg   <= ovf ? PCT_FULL : '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[PCT_W-2:0], 1'b0};
            q_reg   <= {q_reg[PCT_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: design/bwrm_dp.sv
// bwrm_dp: datapath with request register, statistics, counters and result register
// depends on bwrm_pkg and bwrm_div

module bwrm_dp #(
    parameter int FILL_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bwrm_pkg::dp_cmd_t     cmd,
    output bwrm_pkg::dp_status_t  status,
    input  bwrm_pkg::cfg_t        cfg,
    input  bwrm_pkg::item_t       item,
    output bwrm_pkg::result_t     result
);
    import bwrm_pkg::*;

    localparam logic [FILL_W-1:0] FILL_MASK = (FILL_BITS >= FILL_W) ? {FILL_W{1'b1}} :
                                              FILL_W'((64'd1 << FILL_BITS) - 64'd1);

    item_t              item_reg;
    result_t            out_reg;
    logic               smp_reg;
    logic               req_reg;
    logic               refill_reg;
    logic [PCT_W-1:0]   last_reg;
    logic [PCT_W-1:0]   lowest_reg;
    logic [PCT_W-1:0]   highest_reg;
    logic [PCT_W-1:0]   mean_reg;
    logic [SUM_W-1:0]   pct_sum_reg;
    logic [SUM_W-1:0]   count_reg;
    logic [CNT_W-1:0]   chunk_reg;
    logic [SUM_W-1:0]   byte_reg;
    logic [SUM_W-1:0]   tick_reg;

    logic [FILL_W-1:0]  fill_m;
    logic [FILL_W-1:0]  cap_m;
    logic [FILL_W+6:0]  fill100;
    logic [SUM_W-1:0]   div_n;
    logic [SUM_W-1:0]   div_d;
    logic               div_done;
    logic [PCT_W-1:0]   div_q;
    logic [PCT_W-1:0]   q_sat;
    logic               refill_next;
    logic               req_next;
    logic [CNT_W-1:0]   produced;

    // operand preparation, fill * 100 as shift and add
    assign fill_m  = item_reg.fill_bytes & FILL_MASK;
    assign cap_m   = item_reg.capacity_bytes & FILL_MASK;
    assign fill100 = {1'b0, fill_m, 6'b0} + {2'b0, fill_m, 5'b0} + {5'b0, fill_m, 2'b0};

    assign div_n = cmd.div_sel_mean ? pct_sum_reg : {{(SUM_W-FILL_W-7){1'b0}}, fill100};
    assign div_d = cmd.div_sel_mean ? count_reg   : {{(SUM_W-FILL_W){1'b0}}, cap_m};

    bwrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_sat = (div_q > PCT_FULL) ? PCT_FULL : div_q;

    // hysteresis flag and update decision
    always_comb
    begin
        if (q_sat <= cfg.low_mark_pct)
        begin
            refill_next = 1'b1;
        end
        else if (q_sat >= cfg.high_mark_pct)
        begin
            refill_next = 1'b0;
        end
        else
        begin
            refill_next = refill_reg;
        end
        req_next = refill_next | (q_sat < cfg.target_pct);
    end

    // bytes produced, counter wrap takes the new value as is
    assign produced = (item_reg.played_after >= item_reg.played_before) ?
                      (item_reg.played_after - item_reg.played_before) :
                      item_reg.played_after;

    assign status.sampleable = item_reg.playing & (cap_m != '0);
    assign status.div_done   = div_done;

    // request register
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
    end

    // statistics and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_reg     <= 1'b0;
            req_reg     <= 1'b0;
            refill_reg  <= 1'b0;
            last_reg    <= '0;
            lowest_reg  <= PCT_FULL;
            highest_reg <= '0;
            mean_reg    <= MEAN_RESET;
            pct_sum_reg <= '0;
            count_reg   <= '0;
            chunk_reg   <= '0;
            byte_reg    <= '0;
            tick_reg    <= '0;
        end
        else
        begin
            if (cmd.check)
            begin
                smp_reg <= status.sampleable;
                req_reg <= 1'b0;
            end
            if (cmd.apply_pct)
            begin
                last_reg    <= q_sat;
                lowest_reg  <= (q_sat < lowest_reg) ? q_sat : lowest_reg;
                highest_reg <= (q_sat > highest_reg) ? q_sat : highest_reg;
                pct_sum_reg <= pct_sum_reg + {{(SUM_W-PCT_W){1'b0}}, q_sat};
                count_reg   <= count_reg + 1'b1;
                refill_reg  <= refill_next;
                req_reg     <= req_next;
                if (req_next && (item_reg.played_after != item_reg.played_before))
                begin
                    chunk_reg <= chunk_reg + 1'b1;
                    byte_reg  <= byte_reg + {{(SUM_W-CNT_W){1'b0}}, produced};
                    tick_reg  <= tick_reg + item_reg.read_ticks;
                end
            end
            // mean holds its value when the sample count has wrapped to zero
            if (cmd.apply_mean && (count_reg != '0))
            begin
                mean_reg <= q_sat;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.sampled        <= smp_reg;
            out_reg.current_pct    <= last_reg;
            out_reg.min_pct        <= lowest_reg;
            out_reg.max_pct        <= highest_reg;
            out_reg.avg_pct        <= mean_reg;
            out_reg.refilling      <= refill_reg;
            out_reg.update_request <= req_reg;
            out_reg.chunks_total   <= chunk_reg;
            out_reg.bytes_total    <= byte_reg;
            out_reg.ticks_total    <= tick_reg;
        end
    end

    assign result = out_reg;

endmodule

// File: design/bwrm_ctrl.sv
// bwrm_ctrl: sequencing state machine and result valid flag
// depends on bwrm_pkg

module bwrm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  bwrm_pkg::dp_status_t  status,
    output bwrm_pkg::dp_cmd_t     cmd
);
    import bwrm_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_PCT     = 3'd2;
    localparam logic [2:0] S_MEAN_GO = 3'd3;
    localparam logic [2:0] S_MEAN    = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       slot_free;

    assign slot_free = ~out_valid_reg | result_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.sampleable)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_PCT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_PCT:
            begin
                if (status.div_done)
                begin
                    cmd.apply_pct = 1'b1;
                    state_next    = S_MEAN_GO;
                end
            end
            S_MEAN_GO:
            begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_mean = 1'b1;
                state_next       = S_MEAN;
            end
            S_MEAN:
            begin
                if (status.div_done)
                begin
                    cmd.apply_mean = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// File: design/buffer_watermark_refill_monitor.sv
// buffer_watermark_refill_monitor: top level with config registers, controller and datapath
// depends on bwrm_pkg, bwrm_ctrl, bwrm_dp
//
// Usage:
//   item/item_valid/item_ready carries one buffer status request, result/result_valid/
//   result_ready returns one result per request, in order.
//   The marks are to be written through the APB-style port only while the block is idle;
//   the block itself does not enforce this. An ignored request (not playing or zero
//   capacity) passes through the check and emit states; a sampled request passes through
//   the check, percent, mean start, mean and emit states, with two passes of up to 7 steps
//   each through the shared serial divider (percent, then running mean).
//   Requests are handled one at a time; the next is accepted once the previous
//   result sits in the output register.
//   Reset clears statistics and counters (min 100, mean 80, rest 0) and loads the
//   marks with 50, 90 and 75.
//   When the receiver stalls the result holds in the output register, one more
//   request is taken and worked, and it then waits until the register frees.

module buffer_watermark_refill_monitor #(
    parameter int FILL_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  bwrm_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output bwrm_pkg::result_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bwrm_pkg::ADDR_W-1:0]     paddr,
    input  logic [bwrm_pkg::DATA_W-1:0]     pwdata,
    output logic [bwrm_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import bwrm_pkg::*;

    cfg_t        cfg_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // mark registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_mark_pct  <= LOW_RESET;
            cfg_reg.high_mark_pct <= HIGH_RESET;
            cfg_reg.target_pct    <= TGT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_LOW_MARK:  cfg_reg.low_mark_pct  <= pwdata[PCT_W-1:0];
                REG_HIGH_MARK: cfg_reg.high_mark_pct <= pwdata[PCT_W-1:0];
                REG_TARGET:    cfg_reg.target_pct    <= pwdata[PCT_W-1:0];
                default:       ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[3:2])
            REG_LOW_MARK:  prdata = {{(DATA_W-PCT_W){1'b0}}, cfg_reg.low_mark_pct};
            REG_HIGH_MARK: prdata = {{(DATA_W-PCT_W){1'b0}}, cfg_reg.high_mark_pct};
            REG_TARGET:    prdata = {{(DATA_W-PCT_W){1'b0}}, cfg_reg.target_pct};
            default:       prdata = '0;
        endcase
    end

    bwrm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    bwrm_dp #(
        .FILL_BITS (FILL_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .cfg    (cfg_reg),
        .item   (item),
        .result (result)
    );

endmodule

// File: design/bwrm_checker.sv
// bwrm_checker: port-level assertions for the monitor, bound to the top level
// depends on bwrm_pkg and buffer_watermark_refill_monitor

module bwrm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic               result_valid,
    input  logic               result_ready,
    input  bwrm_pkg::result_t  result
);
    import bwrm_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second request accepted while one is in work");

    // ignored request never asks for an update
    a_skip_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sampled |-> !result.update_request)
        else $error("update requested for an ignored request");

    // sampled percent lies between min and max, and never above full
    a_pct_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sampled |->
            result.min_pct <= result.current_pct && result.current_pct <= result.max_pct
            && result.max_pct <= PCT_FULL)
        else $error("percent outside min/max range");

endmodule

bind buffer_watermark_refill_monitor bwrm_checker u_bwrm_checker (.*);
